// ===== src/crp_pkg.sv =====
// Shared types and constants for the cache replacement policy core.
// Used by crp_way_unit and cache_replacement_policy_core; no dependencies.
package crp_pkg;

   localparam int WAYS        = 4;
   localparam int ADDR_BITS   = 32;
   localparam int COUNT_BITS  = 16;
   localparam int TOTAL_BITS  = 32;
   localparam int SLOT_BITS   = 2;
   localparam int EV_BITS     = 32;
   localparam int WAY_BITS    = $clog2(WAYS);
   localparam int NV_BITS     = $clog2(WAYS + 1);
   localparam int POLICY_BITS = 2;

   localparam int REQ_DATA_BITS = ((ADDR_BITS + 7) / 8) * 8;
   localparam int RSP_RAW_BITS  = 1 + SLOT_BITS + 1 + EV_BITS + 2 * TOTAL_BITS;
   localparam int RSP_DATA_BITS = ((RSP_RAW_BITS + 7) / 8) * 8;

   localparam logic [POLICY_BITS-1:0] POLICY_FIFO  = 2'd0;
   localparam logic [POLICY_BITS-1:0] POLICY_LRU   = 2'd1;
   localparam logic [POLICY_BITS-1:0] POLICY_LFU   = 2'd2;
   localparam logic [POLICY_BITS-1:0] POLICY_RESET = POLICY_LRU;

   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   typedef struct packed {
      logic [ADDR_BITS-1:0]  tag;
      logic                  valid;
      logic [WAY_BITS-1:0]   ins;
      logic [WAY_BITS-1:0]   rec;
      logic [COUNT_BITS-1:0] cnt;
   } crp_entry_type;

   typedef struct packed {
      logic [WAY_BITS-1:0] tgt;
      logic [WAY_BITS-1:0] top;
      logic [WAY_BITS-1:0] old_ins;
      logic [WAY_BITS-1:0] old_rec;
      logic                do_ins;
      logic                do_rec;
   } crp_upd_type;

   typedef struct packed {
      logic                match;
      logic                better;
      logic [WAY_BITS-1:0] ins_next;
      logic [WAY_BITS-1:0] rec_next;
   } crp_unit_out_type;

endpackage

// ===== src/crp_way_unit.sv =====
// Shared per-way compare and rank-adjust unit, applied to one way per cycle.
// Depends on crp_pkg.
module crp_way_unit (
   input  crp_pkg::crp_entry_type            entry,
   input  crp_pkg::crp_entry_type            cand,
   input  logic [crp_pkg::WAY_BITS-1:0]      idx,
   input  logic [crp_pkg::ADDR_BITS-1:0]     addr,
   input  logic [crp_pkg::POLICY_BITS-1:0]   policy,
   input  crp_pkg::crp_upd_type              upd,
   output crp_pkg::crp_unit_out_type         res
);
   import crp_pkg::*;

   always_comb begin
      res.match = entry.valid && (entry.tag == addr);

      case (policy)
         POLICY_FIFO: begin
            res.better = entry.ins < cand.ins;
         end
         POLICY_LFU: begin
            res.better = (entry.cnt < cand.cnt) ||
                         ((entry.cnt == cand.cnt) && (entry.ins < cand.ins));
         end
         default: begin
            res.better = entry.rec < cand.rec;
         end
      endcase

      res.ins_next = entry.ins;
      res.rec_next = entry.rec;
      if (idx == upd.tgt) begin
         if (upd.do_ins) res.ins_next = upd.top;
         if (upd.do_rec) res.rec_next = upd.top;
      end else if (entry.valid) begin
         if (upd.do_ins && (entry.ins > upd.old_ins)) res.ins_next = entry.ins - 1'b1;
         if (upd.do_rec && (entry.rec > upd.old_rec)) res.rec_next = entry.rec - 1'b1;
      end
   end

endmodule

// ===== src/cache_replacement_policy_core.sv =====
// Top level of the cache replacement policy core: sequencer, way state, output register.
// Depends on crp_pkg and crp_way_unit.
// An access scans every way in turn through the single shared way unit, then decides,
// then runs a rank update over every way on a hit or an eviction, then loads the result
// once the output register is free; a fill into an empty way skips the rank update, and a
// clear goes straight to loading the result. req_tready is high only between items; a
// waiting result sits in the output register and does not hold off the next request. csr writes are always accepted.
module cache_replacement_policy_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] address
   input  logic [crp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [0] opcode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] hit, [2:1] slot, [3] evicted_valid, [35:4] evicted_address,
   // [67:36] hit_total, [99:68] miss_total, [103:100] zero
   output logic [crp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [crp_pkg::POLICY_BITS-1:0]     csr_data
);
   import crp_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;
   localparam logic [1:0] S_UPDATE = 2'd3;
   localparam logic [2:0] S_DONE_N = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [WAY_BITS-1:0]    idx_ff, idx_in;
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;
   logic                   hit_ff, hit_in;
   logic [WAY_BITS-1:0]    way_ff, way_in;
   logic [COUNT_BITS-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [WAY_BITS-1:0]    hit_rec_ff, hit_rec_in;
   logic [NV_BITS-1:0]     nvalid_ff, nvalid_in;
   logic                   empty_found_ff, empty_found_in;
   logic [WAY_BITS-1:0]    empty_ff, empty_in;
   logic [WAY_BITS-1:0]    vic_ff, vic_in;
   crp_entry_type          vic_entry_ff, vic_entry_in;
   crp_upd_type            upd_ff, upd_in;
   logic                   ev_valid_ff, ev_valid_in;
   logic [EV_BITS-1:0]     ev_addr_ff, ev_addr_in;
   logic [TOTAL_BITS-1:0]  hits_ff, hits_in;
   logic [TOTAL_BITS-1:0]  misses_ff, misses_in;
   logic [POLICY_BITS-1:0] policy_ff, policy_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [ADDR_BITS-1:0]   tag_ff   [WAYS];
   logic                   valid_ff [WAYS];
   logic [WAY_BITS-1:0]    ins_ff   [WAYS];
   logic [WAY_BITS-1:0]    rec_ff   [WAYS];
   logic [COUNT_BITS-1:0]  cnt_ff   [WAYS];

   logic                   clear_we, fill_we, tag_we, cnt_we, upd_we;
   logic [WAY_BITS-1:0]    wr_way;
   logic [COUNT_BITS-1:0]  cnt_wr;
   logic                   idx_last, req_xfer, rsp_load;
   crp_entry_type          entry;
   crp_unit_out_type       unit_res;

   always_comb begin
      entry.tag   = tag_ff[idx_ff];
      entry.valid = valid_ff[idx_ff];
      entry.ins   = ins_ff[idx_ff];
      entry.rec   = rec_ff[idx_ff];
      entry.cnt   = cnt_ff[idx_ff];
   end

   crp_way_unit u_way_unit (
      .entry  (entry),
      .cand   (vic_entry_ff),
      .idx    (idx_ff),
      .addr   (addr_ff),
      .policy (policy_ff),
      .upd    (upd_ff),
      .res    (unit_res)
   );

   assign req_tready = (state_ff == {1'b0, S_IDLE});
   assign req_xfer   = req_tvalid && req_tready;
   assign idx_last   = (idx_ff == WAY_BITS'(WAYS - 1));
   assign rsp_load   = (state_ff == S_DONE_N) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      addr_in        = addr_ff;
      hit_in         = hit_ff;
      way_in         = way_ff;
      hit_cnt_in     = hit_cnt_ff;
      hit_rec_in     = hit_rec_ff;
      nvalid_in      = nvalid_ff;
      empty_found_in = empty_found_ff;
      empty_in       = empty_ff;
      vic_in         = vic_ff;
      vic_entry_in   = vic_entry_ff;
      upd_in         = upd_ff;
      ev_valid_in    = ev_valid_ff;
      ev_addr_in     = ev_addr_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      policy_in      = (csr_valid && csr_ready) ? csr_data : policy_ff;
      clear_we       = 1'b0;
      fill_we        = 1'b0;
      tag_we         = 1'b0;
      cnt_we         = 1'b0;
      upd_we         = 1'b0;
      wr_way         = way_ff;
      cnt_wr         = COUNT_BITS'(1);

      case (state_ff)
         {1'b0, S_IDLE}: begin
            if (req_xfer) begin
               addr_in        = req_tdata[ADDR_BITS-1:0];
               hit_in         = 1'b0;
               way_in         = '0;
               ev_valid_in    = 1'b0;
               ev_addr_in     = '0;
               nvalid_in      = '0;
               empty_found_in = 1'b0;
               idx_in         = '0;
               if (req_tuser == OP_CLEAR) begin
                  clear_we  = 1'b1;
                  hits_in   = '0;
                  misses_in = '0;
                  state_in  = S_DONE_N;
               end else begin
                  state_in = {1'b0, S_SCAN};
               end
            end
         end
         {1'b0, S_SCAN}: begin
            if (entry.valid) begin
               nvalid_in = nvalid_ff + 1'b1;
               if (unit_res.match && !hit_ff) begin
                  hit_in     = 1'b1;
                  way_in     = idx_ff;
                  hit_cnt_in = entry.cnt;
                  hit_rec_in = entry.rec;
               end
            end else if (!empty_found_ff) begin
               empty_found_in = 1'b1;
               empty_in       = idx_ff;
            end
            if ((idx_ff == '0) || unit_res.better) begin
               vic_in       = idx_ff;
               vic_entry_in = entry;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_last) state_in = {1'b0, S_DECIDE};
         end
         {1'b0, S_DECIDE}: begin
            idx_in = '0;
            if (hit_ff) begin
               if (hits_ff != TOTAL_MAX) hits_in = hits_ff + 1'b1;
               cnt_we = 1'b1;
               wr_way = way_ff;
               cnt_wr = (hit_cnt_ff != COUNT_MAX) ? hit_cnt_ff + 1'b1 : hit_cnt_ff;
               upd_in.tgt     = way_ff;
               upd_in.top     = WAY_BITS'(nvalid_ff - 1'b1);
               upd_in.old_ins = '0;
               upd_in.old_rec = hit_rec_ff;
               upd_in.do_ins  = 1'b0;
               upd_in.do_rec  = 1'b1;
               state_in       = {1'b0, S_UPDATE};
            end else begin
               if (misses_ff != TOTAL_MAX) misses_in = misses_ff + 1'b1;
               tag_we = 1'b1;
               cnt_we = 1'b1;
               if (nvalid_ff < NV_BITS'(WAYS)) begin
                  fill_we  = 1'b1;
                  wr_way   = empty_ff;
                  way_in   = empty_ff;
                  state_in = S_DONE_N;
               end else begin
                  wr_way         = vic_ff;
                  way_in         = vic_ff;
                  ev_valid_in    = 1'b1;
                  ev_addr_in     = EV_BITS'(vic_entry_ff.tag);
                  upd_in.tgt     = vic_ff;
                  upd_in.top     = WAY_BITS'(WAYS - 1);
                  upd_in.old_ins = vic_entry_ff.ins;
                  upd_in.old_rec = vic_entry_ff.rec;
                  upd_in.do_ins  = 1'b1;
                  upd_in.do_rec  = 1'b1;
                  state_in       = {1'b0, S_UPDATE};
               end
            end
         end
         {1'b0, S_UPDATE}: begin
            upd_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_last) state_in = S_DONE_N;
         end
         S_DONE_N: begin
            if (rsp_load) state_in = {1'b0, S_IDLE};
         end
         default: begin
            state_in = {1'b0, S_IDLE};
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_BITS'({misses_ff, hits_ff, ev_addr_ff, ev_valid_ff,
                                        SLOT_BITS'(way_ff), hit_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= {1'b0, S_IDLE};
         policy_ff    <= POLICY_RESET;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      addr_ff        <= addr_in;
      hit_ff         <= hit_in;
      way_ff         <= way_in;
      hit_cnt_ff     <= hit_cnt_in;
      hit_rec_ff     <= hit_rec_in;
      nvalid_ff      <= nvalid_in;
      empty_found_ff <= empty_found_in;
      empty_ff       <= empty_in;
      vic_ff         <= vic_in;
      vic_entry_ff   <= vic_entry_in;
      upd_ff         <= upd_in;
      ev_valid_ff    <= ev_valid_in;
      ev_addr_ff     <= ev_addr_in;
      rsp_data_ff    <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (tag_we) tag_ff[wr_way] <= addr_ff;
      if (fill_we) begin
         ins_ff[wr_way] <= WAY_BITS'(nvalid_ff);
         rec_ff[wr_way] <= WAY_BITS'(nvalid_ff);
      end else if (upd_we) begin
         ins_ff[idx_ff] <= unit_res.ins_next;
         rec_ff[idx_ff] <= unit_res.rec_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_we) begin
         for (int i = 0; i < WAYS; i++) begin
            valid_ff[i] <= 1'b0;
            cnt_ff[i]   <= '0;
         end
      end else begin
         if (fill_we) valid_ff[wr_way] <= 1'b1;
         if (cnt_we) cnt_ff[wr_way] <= cnt_wr;
      end
   end

   logic all_valid;
   always_comb begin
      all_valid = 1'b1;
      for (int i = 0; i < WAYS; i++) all_valid = all_valid & valid_ff[i];
   end

   a_access_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_tuser == OP_ACCESS)) |=>
         (state_ff == {1'b0, S_SCAN}) && (idx_ff == '0))
      else $error("access did not start a scan at way zero");

   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE_N) && ev_valid_ff) |-> all_valid)
      else $error("eviction reported while an empty way exists");

   a_hit_way_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE_N) && hit_ff) |-> valid_ff[way_ff])
      else $error("hit reported on an invalid way");

   a_totals_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == {1'b0, S_DECIDE}) |=>
         (hits_ff >= $past(hits_ff)) && (misses_ff >= $past(misses_ff)))
      else $error("running total went backwards on an access");

   a_hit_not_evict: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE_N) |-> !(hit_ff && ev_valid_ff))
      else $error("hit and eviction reported together");

endmodule
